@@ sv/bwc_pkg.sv @@
// Shared types, codes and helpers for the boost window controller.
// No dependencies; every other module in sv/ imports this package.
`timescale 1ns / 1ps

package bwc_pkg;

    // Countdown timer width
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // Screen-on wake window in ticks
    localparam logic [15:0] WAKE_TICKS = 16'd500;

    // Event kinds
    localparam logic [2:0] K_TICK       = 3'd0;
    localparam logic [2:0] K_INPUT      = 3'd1;
    localparam logic [2:0] K_FLEX       = 3'd2;
    localparam logic [2:0] K_MAX        = 3'd3;
    localparam logic [2:0] K_WAKE       = 3'd4;
    localparam logic [2:0] K_SCREEN_ON  = 3'd5;
    localparam logic [2:0] K_SCREEN_OFF = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] R_DEVICE_ENABLED   = 3'd0;
    localparam logic [2:0] R_INPUT_TICKS      = 3'd1;
    localparam logic [2:0] R_FLEX_TICKS       = 3'd2;
    localparam logic [2:0] R_BOOST_FREQ       = 3'd3;
    localparam logic [2:0] R_MAX_FREQ         = 3'd4;
    localparam logic [2:0] R_LOWEST_FREQ      = 3'd5;

    // Boost flag bit positions
    localparam int F_INPUT = 0;
    localparam int F_FLEX  = 1;
    localparam int F_WAKE  = 2;
    localparam int F_MAX   = 3;

    typedef struct packed {
        logic        device_enabled;
        logic [15:0] input_boost_ticks;
        logic [15:0] flex_boost_ticks;
        logic [31:0] boost_frequency;
        logic [31:0] maximum_frequency;
        logic [31:0] lowest_table_frequency;
    } cfg_t;

    typedef struct packed {
        logic       disp_on;
        logic [3:0] flags;     // input, flex, wake, max from bit 0
    } status_t;

    // Saturating load of a 16-bit window into the timer width
    function automatic logic [TIMER_BITS-1:0] clamp_load(input logic [15:0] d);
        logic [31:0] wide;
        wide = 32'(d);
        if ((wide >> TIMER_BITS) != 32'd0) begin
            return TIMER_MAX;
        end
        return TIMER_BITS'(wide);
    endfunction

endpackage

@@ sv/bwc_cfg_regs.sv @@
// Configuration register file for the boost window controller.
// Depends on bwc_pkg (cfg_t, register index codes).
`timescale 1ns / 1ps

module bwc_cfg_regs
    import bwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                R_DEVICE_ENABLED: cfg_next.device_enabled         = wr_data[0];
                R_INPUT_TICKS:    cfg_next.input_boost_ticks      = wr_data[15:0];
                R_FLEX_TICKS:     cfg_next.flex_boost_ticks       = wr_data[15:0];
                R_BOOST_FREQ:     cfg_next.boost_frequency        = wr_data;
                R_MAX_FREQ:       cfg_next.maximum_frequency      = wr_data;
                R_LOWEST_FREQ:    cfg_next.lowest_table_frequency = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_enabled         <= 1'b0;
            cfg_reg.input_boost_ticks      <= 16'd64;
            cfg_reg.flex_boost_ticks       <= 16'd64;
            cfg_reg.boost_frequency        <= 32'd0;
            cfg_reg.maximum_frequency      <= 32'hFFFF_FFFF;
            cfg_reg.lowest_table_frequency <= 32'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/bwc_in_reg.sv @@
// Input register stage: holds one event item until the update stage takes it.
// Depends on bwc_pkg (wildcard import only).
`timescale 1ns / 1ps

module bwc_in_reg
    import bwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  in_kind,
    input  logic [15:0] in_duration,
    input  logic        take,       // update stage consumes the held item
    output logic        held_valid,
    output logic [2:0]  held_kind,
    output logic [15:0] held_duration
);

    logic        valid_reg;
    logic        valid_next;
    logic [2:0]  kind_reg;
    logic [15:0] duration_reg;

    assign in_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            kind_reg     <= in_kind;
            duration_reg <= in_duration;
        end
    end

    assign held_valid    = valid_reg;
    assign held_kind     = kind_reg;
    assign held_duration = duration_reg;

endmodule

@@ sv/bwc_state.sv @@
// Boost state: screen flag, boost flags, three countdown timers and pending bits.
// Depends on bwc_pkg (cfg_t, status_t, kind codes, clamp_load).
`timescale 1ns / 1ps

module bwc_state
    import bwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [2:0]  kind,
    input  logic [15:0] duration,
    input  cfg_t        cfg,
    output status_t     status_next
);

    logic                  disp_on_reg, disp_on_next;
    logic [3:0]            flags_reg, flags_next;
    logic [2:0]            pend_reg, pend_next;     // input, flex, max
    logic [TIMER_BITS-1:0] in_tmr_reg, in_tmr_next;
    logic [TIMER_BITS-1:0] fx_tmr_reg, fx_tmr_next;
    logic [TIMER_BITS-1:0] mx_tmr_reg, mx_tmr_next;
    logic                  live;
    logic                  wake_ok;

    assign live    = cfg.device_enabled && disp_on_reg;
    assign wake_ok = cfg.device_enabled && !disp_on_reg;

    always_comb begin
        disp_on_next = disp_on_reg;
        flags_next   = flags_reg;
        pend_next    = pend_reg;
        in_tmr_next  = in_tmr_reg;
        fx_tmr_next  = fx_tmr_reg;
        mx_tmr_next  = mx_tmr_reg;

        case (kind)
            K_TICK: begin
                if (pend_reg[0]) begin
                    if (in_tmr_reg <= TIMER_BITS'(1)) begin
                        in_tmr_next        = '0;
                        pend_next[0]       = 1'b0;
                        flags_next[F_INPUT] = 1'b0;
                    end else begin
                        in_tmr_next = in_tmr_reg - TIMER_BITS'(1);
                    end
                end
                if (pend_reg[1]) begin
                    if (fx_tmr_reg <= TIMER_BITS'(1)) begin
                        fx_tmr_next        = '0;
                        pend_next[1]       = 1'b0;
                        flags_next[F_FLEX] = 1'b0;
                    end else begin
                        fx_tmr_next = fx_tmr_reg - TIMER_BITS'(1);
                    end
                end
                // max timer is shared by the wake and max boosts
                if (pend_reg[2]) begin
                    if (mx_tmr_reg <= TIMER_BITS'(1)) begin
                        mx_tmr_next        = '0;
                        pend_next[2]       = 1'b0;
                        flags_next[F_WAKE] = 1'b0;
                        flags_next[F_MAX]  = 1'b0;
                    end else begin
                        mx_tmr_next = mx_tmr_reg - TIMER_BITS'(1);
                    end
                end
            end
            K_INPUT: begin
                if (live) begin
                    in_tmr_next = clamp_load(cfg.input_boost_ticks);
                    if (!pend_reg[0]) begin
                        pend_next[0]        = 1'b1;
                        flags_next[F_INPUT] = 1'b1;
                    end
                end
            end
            K_FLEX: begin
                if (live) begin
                    fx_tmr_next = clamp_load(cfg.flex_boost_ticks);
                    if (!pend_reg[1]) begin
                        pend_next[1]       = 1'b1;
                        flags_next[F_FLEX] = 1'b1;
                    end
                end
            end
            K_MAX: begin
                if (live) begin
                    mx_tmr_next = clamp_load(duration);
                    if (!pend_reg[2]) begin
                        pend_next[2]      = 1'b1;
                        flags_next[F_MAX] = 1'b1;
                    end
                end
            end
            K_WAKE: begin
                if (wake_ok) begin
                    mx_tmr_next = clamp_load(duration);
                    if (!pend_reg[2]) begin
                        pend_next[2]       = 1'b1;
                        flags_next[F_WAKE] = 1'b1;
                    end
                end
            end
            K_SCREEN_ON: begin
                if (wake_ok) begin
                    mx_tmr_next = clamp_load(WAKE_TICKS);
                    if (!pend_reg[2]) begin
                        pend_next[2]       = 1'b1;
                        flags_next[F_WAKE] = 1'b1;
                    end
                end
                disp_on_next = 1'b1;
            end
            K_SCREEN_OFF: begin
                disp_on_next = 1'b0;
                flags_next   = '0;
            end
            default: begin
                disp_on_next = disp_on_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disp_on_reg <= 1'b1;
            flags_reg   <= '0;
            pend_reg    <= '0;
            in_tmr_reg  <= '0;
            fx_tmr_reg  <= '0;
            mx_tmr_reg  <= '0;
        end else if (step) begin
            disp_on_reg <= disp_on_next;
            flags_reg   <= flags_next;
            pend_reg    <= pend_next;
            in_tmr_reg  <= in_tmr_next;
            fx_tmr_reg  <= fx_tmr_next;
            mx_tmr_reg  <= mx_tmr_next;
        end
    end

    assign status_next.disp_on = disp_on_next;
    assign status_next.flags   = flags_next;

endmodule

@@ sv/bwc_out_reg.sv @@
// Result stage: forms the frequency floor and max flag, holds the result item.
// Depends on bwc_pkg (cfg_t, status_t, flag positions).
`timescale 1ns / 1ps

module bwc_out_reg
    import bwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  status_t     status,
    input  cfg_t        cfg,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_min_frequency,
    output logic        out_max_boost_on,
    output logic [4:0]  out_boost_flags
);

    logic        valid_reg, valid_next;
    logic [31:0] minf_reg, minf_next;
    logic        maxb_reg, maxb_next;
    logic [4:0]  flags_reg, flags_next;
    logic [31:0] capped;

    assign free = !valid_reg || out_ready;

    assign capped = (cfg.boost_frequency < cfg.maximum_frequency) ?
                    cfg.boost_frequency : cfg.maximum_frequency;

    always_comb begin
        if (!status.disp_on) begin
            minf_next = cfg.lowest_table_frequency;
            maxb_next = status.flags[F_WAKE];
        end else begin
            minf_next = (status.flags[F_INPUT] || status.flags[F_FLEX]) ?
                        capped : cfg.lowest_table_frequency;
            maxb_next = status.flags[F_MAX];
        end
        flags_next = {status.flags, status.disp_on};
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            minf_reg  <= minf_next;
            maxb_reg  <= maxb_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid         = valid_reg;
    assign out_min_frequency = minf_reg;
    assign out_max_boost_on  = maxb_reg;
    assign out_boost_flags   = flags_reg;

endmodule

@@ sv/boost_window_controller.sv @@
// Top level of the boost window controller.
// Depends on bwc_pkg, bwc_cfg_regs, bwc_in_reg, bwc_state and bwc_out_reg.
`timescale 1ns / 1ps

// Frequency-floor boost controller for one device.
//
// Event channel (s_*): one item per event. s_tuser carries the event kind
// (tick, input, flex kick, max kick, wake kick, screen on, screen off);
// s_tdata carries the boost duration used by max and wake kicks.
// Result channel (m_*): exactly one item per event, in order. m_tdata is
// the applied minimum frequency; m_tuser holds the max-boost flag and the
// five status flags (screen on, input, flex, wake, max).
// Config channel (cfg_*): always ready; index selects the register, a write
// to an index past the last register is dropped. Write only while idle.
//
// Path: the input register holds the accepted item; the state update and the
// result register load then happen together once the result slot is free.
// Throughput: one item per cycle while the receiver keeps m_tready high.
// When the receiver stalls the result register holds its item, the input
// register fills, and s_tready drops until m_tready returns.
// Reset (aresetn low, synchronous): screen on, all boosts and timers clear,
// registers take their reset values, both channels empty.

module boost_window_controller
    import bwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // event channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] duration
    input  logic [2:0]  s_tuser,    // [2:0] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] min_frequency
    output logic [5:0]  m_tuser,    // [0] max_boost_on, [5:1] boost_flags
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t        cfg;
    status_t     status_next;
    logic        held_valid;
    logic [2:0]  held_kind;
    logic [15:0] held_duration;
    logic        out_free;
    logic        advance;

    assign cfg_ready = 1'b1;

    // an event moves through the update stage when the result slot is open
    assign advance = held_valid && out_free;

    bwc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bwc_in_reg u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_duration   (s_tdata),
        .take          (advance),
        .held_valid    (held_valid),
        .held_kind     (held_kind),
        .held_duration (held_duration)
    );

    bwc_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .kind        (held_kind),
        .duration    (held_duration),
        .cfg         (cfg),
        .status_next (status_next)
    );

    bwc_out_reg u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (advance),
        .status            (status_next),
        .cfg               (cfg),
        .free              (out_free),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_min_frequency (m_tdata),
        .out_max_boost_on  (m_tuser[0]),
        .out_boost_flags   (m_tuser[5:1])
    );

endmodule

@@ test/tb_boost_window_controller.sv @@
// Self-checking testbench for boost_window_controller.
// Depends on bwc_pkg (event kinds, register indexes, flag positions, timer width)
// and on the boost_window_controller RTL.
`timescale 1ns / 1ps

module tb_boost_window_controller;
    import bwc_pkg::*;

    // Kind 7 is not decoded by the block; it must leave the state alone
    localparam logic [2:0] K_UNUSED = 3'd7;
    // Indexes past the last register; writes to them are dropped
    localparam logic [2:0] R_SPARE_LO = 3'd6;
    localparam logic [2:0] R_SPARE_HI = 3'd7;

    // Window slots: input, flex, and the max timer shared by max and wake
    localparam int W_INPUT = 0;
    localparam int W_FLEX  = 1;
    localparam int W_MAX   = 2;

    localparam logic [3:0] CLR_INPUT = 4'(1 << F_INPUT);
    localparam logic [3:0] CLR_FLEX  = 4'(1 << F_FLEX);
    localparam logic [3:0] CLR_MAX   = 4'((1 << F_WAKE) | (1 << F_MAX));

    localparam int HOLD_AFTER   = 300;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int SETTLE       = 8;
    localparam int PHASE_EVENTS = 200;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] duration;
    } boost_event_t;

    typedef struct packed {
        logic [31:0] floor_freq;
        logic        max_on;
        logic [4:0]  flags;
    } floor_result_t;

    // DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // [15:0] duration
    logic [2:0]  s_tuser   = '0;    // [2:0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [31:0] min_frequency
    logic [5:0]  m_tuser;           // [0] max_boost_on, [5:1] boost_flags
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    boost_window_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the boost state
    // ------------------------------------------------------------------
    cfg_t                  regs;
    logic                  screen_is_on;
    logic [3:0]            boost_on;       // flag positions from the package
    logic [TIMER_BITS-1:0] win_count [3];
    logic [2:0]            win_pending;

    boost_event_t  event_backlog [$];
    floor_result_t pending_floors [$];

    int error_count  = 0;
    int results_seen = 0;

    // Kick a window: a load always happens (saturated to the timer range),
    // the flag only comes up when the window was idle.
    function automatic void load_window(int w, int flag, logic [15:0] ticks);
        if ({16'd0, ticks} > 32'(TIMER_MAX)) begin
            win_count[w] = TIMER_MAX;
        end else begin
            win_count[w] = TIMER_BITS'(ticks);
        end
        if (!win_pending[w]) begin
            win_pending[w] = 1'b1;
            boost_on[flag] = 1'b1;
        end
    endfunction

    // One tick on one window; a count of 0 or 1 expires now
    function automatic void count_down(int w, logic [3:0] clear);
        if (!win_pending[w]) begin
            return;
        end
        if (win_count[w] <= 1) begin
            win_count[w]   = '0;
            win_pending[w] = 1'b0;
            boost_on       = boost_on & ~clear;
        end else begin
            win_count[w] = win_count[w] - 1'b1;
        end
    endfunction

    // Apply one event to the predicted state and return the floor it reports
    function automatic floor_result_t advance_boost(logic [2:0] kind, logic [15:0] dur);
        floor_result_t res;
        logic          live;
        live = regs.device_enabled && screen_is_on;
        case (kind)
            K_TICK: begin
                count_down(W_INPUT, CLR_INPUT);
                count_down(W_FLEX, CLR_FLEX);
                count_down(W_MAX, CLR_MAX);
            end
            K_INPUT: begin
                if (live) load_window(W_INPUT, F_INPUT, regs.input_boost_ticks);
            end
            K_FLEX: begin
                if (live) load_window(W_FLEX, F_FLEX, regs.flex_boost_ticks);
            end
            K_MAX: begin
                if (live) load_window(W_MAX, F_MAX, dur);
            end
            K_WAKE: begin
                if (regs.device_enabled && !screen_is_on) load_window(W_MAX, F_WAKE, dur);
            end
            K_SCREEN_ON: begin
                // wake kick goes first, so it only counts coming from screen off
                if (regs.device_enabled && !screen_is_on) begin
                    load_window(W_MAX, F_WAKE, WAKE_TICKS);
                end
                screen_is_on = 1'b1;
            end
            K_SCREEN_OFF: begin
                // flags drop, timers keep running
                screen_is_on = 1'b0;
                boost_on     = '0;
            end
            default: begin
            end
        endcase

        res.flags = {boost_on, screen_is_on};
        if (!screen_is_on) begin
            res.floor_freq = regs.lowest_table_frequency;
            res.max_on     = boost_on[F_WAKE];
        end else begin
            if (boost_on[F_INPUT] || boost_on[F_FLEX]) begin
                res.floor_freq = (regs.boost_frequency < regs.maximum_frequency) ?
                                 regs.boost_frequency : regs.maximum_frequency;
            end else begin
                res.floor_freq = regs.lowest_table_frequency;
            end
            res.max_on = boost_on[F_MAX];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Event driver: bursts of random length, random gaps between them.
    // Prediction happens at the edge where the item is taken.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_events
        boost_event_t nxt;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            s_tuser     <= K_TICK;
            s_tdata     <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
            regs.device_enabled         = 1'b0;
            regs.input_boost_ticks      = 16'd64;
            regs.flex_boost_ticks       = 16'd64;
            regs.boost_frequency        = 32'd0;
            regs.maximum_frequency      = 32'hFFFF_FFFF;
            regs.lowest_table_frequency = 32'd0;
            screen_is_on = 1'b1;
            boost_on     = '0;
            win_pending  = '0;
            win_count[W_INPUT] = '0;
            win_count[W_FLEX]  = '0;
            win_count[W_MAX]   = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_floors.push_back(advance_boost(s_tuser, s_tdata));
            end
            // an offered item stays put until taken
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    nxt = event_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.kind;
                    s_tdata  <= nxt.duration;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register writes update our copy at the same edge the block takes them
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                R_DEVICE_ENABLED: regs.device_enabled         = cfg_data[0];
                R_INPUT_TICKS:    regs.input_boost_ticks      = cfg_data[15:0];
                R_FLEX_TICKS:     regs.flex_boost_ticks       = cfg_data[15:0];
                R_BOOST_FREQ:     regs.boost_frequency        = cfg_data;
                R_MAX_FREQ:       regs.maximum_frequency      = cfg_data;
                R_LOWEST_FREQ:    regs.lowest_table_frequency = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, switching to a new random mode as it goes,
    // plus one long hold-off so the block backs up into s_tready.
    // ------------------------------------------------------------------
    int rx_cycle  = 0;
    int rx_mode   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) begin
                rx_mode <= $urandom_range(0, 2);
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ((rx_cycle % 5) < 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: in-order compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_floors
        floor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_floors.size() == 0) begin
                $error("unexpected result item: min_frequency %h, m_tuser %b", m_tdata, m_tuser);
                error_count = error_count + 1;
            end else begin
                want = pending_floors.pop_front();
                if (m_tdata !== want.floor_freq) begin
                    $error("min_frequency: expected %h, got %h", want.floor_freq, m_tdata);
                    error_count = error_count + 1;
                end
                if (m_tuser[0] !== want.max_on) begin
                    $error("max_boost_on: expected %b, got %b", want.max_on, m_tuser[0]);
                    error_count = error_count + 1;
                end
                if (m_tuser[5:1] !== want.flags) begin
                    $error("boost_flags: expected %b, got %b", want.flags, m_tuser[5:1]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // No handshake on any channel for too long ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                            (cfg_valid && cfg_ready))) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
        end
        $display("[boost_window_controller] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Upper bits of narrow registers carry noise; the block must mask them
    task automatic set_all(logic en, logic [15:0] in_t, logic [15:0] fx_t,
                           logic [31:0] boost, logic [31:0] maxf, logic [31:0] low);
        write_reg(R_DEVICE_ENABLED, {31'($urandom), en});
        write_reg(R_INPUT_TICKS, {16'($urandom), in_t});
        write_reg(R_FLEX_TICKS, {16'($urandom), fx_t});
        write_reg(R_BOOST_FREQ, boost);
        write_reg(R_MAX_FREQ, maxf);
        write_reg(R_LOWEST_FREQ, low);
        @(negedge aclk);
    endtask

    // Idle means: nothing queued, nothing offered, nothing owed
    task automatic wait_drained();
        do @(negedge aclk);
        while (event_backlog.size() != 0 || s_tvalid || pending_floors.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic queue_event(logic [2:0] kind, logic [15:0] dur);
        boost_event_t ev;
        ev.kind     = kind;
        ev.duration = dur;
        event_backlog.push_back(ev);
    endtask

    // Ticks dominate so windows actually run out; durations mostly short
    task automatic queue_random(int count);
        int pick;
        logic [2:0] kind;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = K_TICK;
            else if (pick < 52) kind = K_INPUT;
            else if (pick < 62) kind = K_FLEX;
            else if (pick < 72) kind = K_MAX;
            else if (pick < 80) kind = K_WAKE;
            else if (pick < 88) kind = K_SCREEN_ON;
            else if (pick < 97) kind = K_SCREEN_OFF;
            else                kind = K_UNUSED;
            queue_event(kind, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 12)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: device disabled, every kick ignored
        queue_event(K_INPUT, 16'd0);
        queue_event(K_MAX, 16'hFFFF);
        queue_event(K_TICK, 16'd0);
        wait_drained();

        // boost above the cap, zero-length flex window
        set_all(1'b1, 16'd2, 16'd0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0001);
        queue_event(K_INPUT, 16'd0);
        queue_event(K_FLEX, 16'd0);
        queue_event(K_MAX, 16'hFFFF);
        queue_event(K_TICK, 16'd0);        // flex window of zero ends here
        queue_event(K_INPUT, 16'd0);       // reload of a running window
        queue_event(K_TICK, 16'd0);
        queue_event(K_TICK, 16'd0);        // input window ends
        queue_event(K_SCREEN_OFF, 16'd0);  // flags drop, max timer still running
        queue_event(K_MAX, 16'd5);         // screen off: ignored
        queue_event(K_WAKE, 16'd3);        // max timer busy: reload only, flag stays low
        queue_event(K_INPUT, 16'd0);       // screen off: ignored
        queue_event(K_TICK, 16'd0);
        queue_event(K_TICK, 16'd0);
        queue_event(K_TICK, 16'd0);        // max timer ends
        queue_event(K_WAKE, 16'd0);        // zero-length wake on an idle timer
        queue_event(K_TICK, 16'd0);
        queue_event(K_SCREEN_ON, 16'hAAAA);  // wake kick of 500 ticks
        queue_event(K_SCREEN_ON, 16'h5555);  // already on: no wake kick
        queue_event(K_UNUSED, 16'h5555);
        queue_event(K_MAX, 16'd0);         // timer busy with wake: reload only
        queue_event(K_TICK, 16'd0);        // shared timer ends: wake and max clear
        queue_event(K_FLEX, 16'd0);
        queue_event(K_TICK, 16'd0);
        wait_drained();

        // random phases over a spread of settings, extremes included
        set_all(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                $urandom, $urandom, $urandom);
        queue_random(PHASE_EVENTS);
        wait_drained();

        set_all(1'b1, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        queue_random(PHASE_EVENTS);
        wait_drained();

        set_all(1'b0, 16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
        write_reg(R_SPARE_LO, $urandom);
        write_reg(R_SPARE_HI, $urandom);
        @(negedge aclk);
        queue_random(PHASE_EVENTS);
        wait_drained();

        set_all(1'b1, 16'hFFFF, 16'hFFFF, $urandom, $urandom, $urandom);
        queue_random(PHASE_EVENTS);
        wait_drained();

        set_all(1'b1, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                $urandom, $urandom, $urandom);
        queue_random(PHASE_EVENTS);
        wait_drained();

        if (pending_floors.size() != 0) begin
            $error("%0d results never arrived", pending_floors.size());
            error_count = error_count + 1;
        end
        if (error_count == 0) begin
            $display("[boost_window_controller] OK");
        end else begin
            $display("[boost_window_controller] ERROR");
        end
        $finish;
    end

endmodule
